// File: hdl/mbe_pkg.sv
// Shared types and constants for the escape-time pixel engine.
package mbe_pkg;

	localparam int C_BITS      = 32;  // width of c_real / c_imag
	localparam int C_FRAC      = 28;  // fraction bits of the c inputs
	localparam int ITER_BITS   = 16;  // iteration count and limit
	localparam int COLOUR_BITS = 8;

	localparam logic [ITER_BITS-1:0]   ITER_LIMIT_RST = 16'd256;
	localparam logic [COLOUR_BITS-1:0] COLOUR_WHITE   = 8'hFF;

	// digit width of the shared multiplier (bits of the second operand per pass)
	localparam int MUL_DIGIT = 16;

	typedef enum logic [1:0] {
		OP_RI,  // re * im
		OP_RR,  // re * re
		OP_II   // im * im
	} mul_op_t;

endpackage

// File: hdl/mbe_cfg_if.sv
// Configuration write channel: iteration limit.
interface mbe_cfg_if
	import mbe_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [ITER_BITS-1:0] max_iterations;

	modport source (output valid, output max_iterations, input ready);
	modport sink   (input valid, input max_iterations, output ready);
endinterface

// File: hdl/mbe_pixel_if.sv
// Pixel channel: complex point c and pixel position.
interface mbe_pixel_if
	import mbe_pkg::*;
#(
	parameter int COORD_BITS = 12
) ();
	logic                     valid;
	logic                     ready;
	logic signed [C_BITS-1:0] c_real;
	logic signed [C_BITS-1:0] c_imag;
	logic [COORD_BITS-1:0]    pixel_x;
	logic [COORD_BITS-1:0]    pixel_y;

	modport source (output valid, output c_real, output c_imag, output pixel_x,
		output pixel_y, input ready);
	modport sink   (input valid, input c_real, input c_imag, input pixel_x,
		input pixel_y, output ready);
endinterface

// File: hdl/mbe_result_if.sv
// Result channel: position, iteration count, escape flag and colour.
interface mbe_result_if
	import mbe_pkg::*;
#(
	parameter int COORD_BITS = 12
) ();
	logic                   valid;
	logic                   ready;
	logic [COORD_BITS-1:0]  out_x;
	logic [COORD_BITS-1:0]  out_y;
	logic [ITER_BITS-1:0]   iterations;
	logic                   escaped;
	logic [COLOUR_BITS-1:0] red;
	logic [COLOUR_BITS-1:0] green;
	logic [COLOUR_BITS-1:0] blue;

	modport source (output valid, output out_x, output out_y, output iterations,
		output escaped, output red, output green, output blue, input ready);
	modport sink   (input valid, input out_x, input out_y, input iterations,
		input escaped, input red, input green, input blue, output ready);
endinterface

// File: hdl/mandelbrot_escape_time_core.sv
// Escape-time pixel engine: iterates z = z*z + c on one shared multiplier.
//
// Channels (valid/ready, one beat = one item):
//   cfg    - write beat sets the iteration limit (reset value 256); always ready.
//            Only write it while no pixel is in flight or waiting on the output.
//   pixel  - c (signed Q4.28) and pixel position. Ready only while the engine
//            is idle; one pixel is worked on at a time.
//   result - position, step count, escape flag and colour, one beat per pixel.
// Sequence: a product is formed digit by digit (NCH = ceil((FRAC_BITS+2)/16)
//   digits, 2 at the default), and an iteration needs three products: re*im,
//   then an update state, then re*re and im*im, then a test state. A pixel
//   that leaves through the |re|,|im| >= 2 check in the update state skips
//   the last two products and the test state.
// The result sits in an output register. A new pixel is taken as soon as the
//   engine is idle, even while the previous result still waits; if the receiver
//   stalls, the next pixel finishes and then waits in the finish state.
// Reset (arst_n low) clears the sequencer and the output valid and restores the
//   limit to 256; no result is pending afterwards.
// Values are Q8.FRAC_BITS internally; the bound test keeps |re|,|im| < 2, so
//   the multiplier operands need only FRAC_BITS+2 bits and no sum overflows.
module mandelbrot_escape_time_core
	import mbe_pkg::*;
#(
	parameter int FRAC_BITS  = 28,
	parameter int COORD_BITS = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	mbe_cfg_if.sink           cfg,
	mbe_pixel_if.sink         pixel,
	mbe_result_if.source      result
);

	// ---- widths derived from the fraction width ----
	localparam int W   = FRAC_BITS + 8;             // z and c, Q8.F
	localparam int MW  = FRAC_BITS + 2;             // multiplier operand, |x| < 2
	localparam int NCH = (MW + MUL_DIGIT - 1) / MUL_DIGIT;  // digits per product
	localparam int BW  = NCH * MUL_DIGIT;           // padded second operand
	localparam int AW  = MW + BW;                   // exact product
	localparam int PW  = FRAC_BITS + 3;             // product after shift, |p| < 4
	localparam int MCW = $clog2(NCH + 1);
	localparam int XW  = C_BITS + FRAC_BITS + 4;    // c shifted up, sign-extended

	localparam logic [W-1:0] TWO_Q =
		{{(W-FRAC_BITS-2){1'b0}}, 2'b10, {FRAC_BITS{1'b0}}};
	localparam logic [W-1:0] NEG_TWO_Q = ~TWO_Q + {{(W-1){1'b0}}, 1'b1};
	localparam logic [PW:0]  FOUR_Q = {2'b01, {(PW-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_UPD,
		ST_TEST,
		ST_FINISH
	} state_t;

	state_t               state_q;
	mul_op_t              op_q;
	logic [MCW-1:0]       mcnt_q;
	logic [ITER_BITS-1:0] max_q;
	logic [ITER_BITS-1:0] cnt_q;
	logic                 esc_q;

	// output register
	logic                   res_valid_q;
	logic [COORD_BITS-1:0]  res_x_q;
	logic [COORD_BITS-1:0]  res_y_q;
	logic [ITER_BITS-1:0]   res_iter_q;
	logic                   res_esc_q;
	logic [COLOUR_BITS-1:0] res_r_q;
	logic [COLOUR_BITS-1:0] res_g_q;
	logic [COLOUR_BITS-1:0] res_b_q;

	// datapath
	logic signed [W-1:0]  cr_q;
	logic signed [W-1:0]  ci_q;
	logic signed [W-1:0]  re_q;
	logic signed [W-1:0]  im_q;
	logic signed [PW-1:0] rr_q;
	logic signed [PW-1:0] ii_q;
	logic signed [PW-1:0] ri_q;
	logic [COORD_BITS-1:0] x_q;
	logic [COORD_BITS-1:0] y_q;

	// shared multiplier
	logic signed [MW-1:0]        a_q;
	logic [BW-1:0]               b_sh_q;
	logic signed [MW+MUL_DIGIT:0] pp_s1;
	logic signed [AW-1:0]        acc_q;

	logic                        pixel_acc;
	logic                        mul_last;
	logic signed [MUL_DIGIT:0]   mul_dig;
	logic signed [MW+MUL_DIGIT:0] pp_d;
	logic signed [AW-1:0]        acc_d;
	logic signed [PW-1:0]        prod;

	logic                        mul_start;
	logic signed [MW-1:0]        mul_a;
	logic signed [MW-1:0]        mul_b;

	logic [XW-1:0]               cr_x;
	logic [XW-1:0]               ci_x;
	logic signed [W-1:0]         re_n;
	logic signed [W-1:0]         im_n;
	logic                        bound_esc;
	logic [PW:0]                 mag_sq;
	logic [COLOUR_BITS-1:0]      col8;
	logic [COLOUR_BITS-1:0]      col4;
	logic [COLOUR_BITS-1:0]      col2;

	assign pixel_acc = pixel.valid && pixel.ready;
	assign pixel.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	assign result.valid      = res_valid_q;
	assign result.out_x      = res_x_q;
	assign result.out_y      = res_y_q;
	assign result.iterations = res_iter_q;
	assign result.escaped    = res_esc_q;
	assign result.red        = res_r_q;
	assign result.green      = res_g_q;
	assign result.blue       = res_b_q;

	// c from Q4.28 to Q8.F: shift up by F, then floor-shift down by 28
	assign cr_x = {{4{pixel.c_real[C_BITS-1]}}, pixel.c_real, {FRAC_BITS{1'b0}}};
	assign ci_x = {{4{pixel.c_imag[C_BITS-1]}}, pixel.c_imag, {FRAC_BITS{1'b0}}};

	// ---- multiplier: MSB digit first (signed), lower digits unsigned ----
	assign mul_last = (mcnt_q == MCW'(NCH));
	assign mul_dig  = (mcnt_q == '0) ?
		{b_sh_q[BW-1], b_sh_q[BW-1 -: MUL_DIGIT]} :
		{1'b0, b_sh_q[BW-1 -: MUL_DIGIT]};
	assign pp_d  = a_q * mul_dig;
	assign acc_d = (mcnt_q == MCW'(1)) ? AW'(pp_s1) : (acc_q <<< MUL_DIGIT) + AW'(pp_s1);
	// exact product floor-shifted by F is just a slice
	assign prod  = acc_d[FRAC_BITS +: PW];

	// ---- step update and bound test ----
	assign re_n = W'(rr_q) - W'(ii_q) + cr_q;
	assign im_n = (W'(ri_q) <<< 1) + ci_q;
	assign bound_esc = (re_n >= $signed(TWO_Q)) || (re_n <= $signed(NEG_TWO_Q)) ||
		(im_n >= $signed(TWO_Q)) || (im_n <= $signed(NEG_TWO_Q));
	assign mag_sq = {1'b0, rr_q} + {1'b0, ii_q};

	// colour bytes, mod 256
	assign col8 = {cnt_q[4:0], 3'b000};
	assign col4 = {cnt_q[5:0], 2'b00};
	assign col2 = {cnt_q[6:0], 1'b0};

	// operand load for the next product
	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			ST_IDLE: begin
				mul_start = pixel_acc;  // first re*im with z = 0
			end
			ST_MUL: begin
				if (mul_last && op_q == OP_RR) begin
					mul_start = 1'b1;
					mul_a     = im_q[MW-1:0];
					mul_b     = im_q[MW-1:0];
				end
			end
			ST_UPD: begin
				mul_start = !bound_esc;
				mul_a     = re_n[MW-1:0];
				mul_b     = re_n[MW-1:0];
			end
			ST_TEST: begin
				mul_start = 1'b1;
				mul_a     = re_q[MW-1:0];
				mul_b     = im_q[MW-1:0];
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_RI;
			mcnt_q      <= '0;
			max_q       <= ITER_LIMIT_RST;
			cnt_q       <= '0;
			esc_q       <= 1'b0;
			res_valid_q <= 1'b0;
			res_x_q     <= '0;
			res_y_q     <= '0;
			res_iter_q  <= '0;
			res_esc_q   <= 1'b0;
			res_r_q     <= '0;
			res_g_q     <= '0;
			res_b_q     <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				max_q <= cfg.max_iterations;
			end
			// the finish state handles its own drain and reload
			if (result.valid && result.ready && state_q != ST_FINISH) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pixel_acc) begin
						cnt_q  <= '0;
						esc_q  <= 1'b0;
						mcnt_q <= '0;
						op_q   <= OP_RI;
						state_q <= (max_q == '0) ? ST_FINISH : ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_last) begin
						mcnt_q <= '0;
						case (op_q)
							OP_RI:   state_q <= ST_UPD;
							OP_RR:   op_q <= OP_II;
							OP_II:   state_q <= ST_TEST;
							default: state_q <= ST_IDLE;
						endcase
					end else begin
						mcnt_q <= mcnt_q + MCW'(1);
					end
				end
				ST_UPD: begin
					cnt_q <= cnt_q + ITER_BITS'(1);
					if (bound_esc) begin
						esc_q   <= 1'b1;
						state_q <= ST_FINISH;
					end else begin
						op_q    <= OP_RR;
						state_q <= ST_MUL;
					end
				end
				ST_TEST: begin
					if (mag_sq >= FOUR_Q) begin
						esc_q   <= 1'b1;
						state_q <= ST_FINISH;
					end else if (cnt_q == max_q) begin
						state_q <= ST_FINISH;
					end else begin
						op_q    <= OP_RI;
						state_q <= ST_MUL;
					end
				end
				ST_FINISH: begin
					if (!res_valid_q || result.ready) begin
						res_valid_q <= 1'b1;
						res_x_q     <= x_q;
						res_y_q     <= y_q;
						res_iter_q  <= cnt_q;
						res_esc_q   <= esc_q;
						res_r_q     <= esc_q ? col8 : COLOUR_WHITE;
						res_g_q     <= esc_q ? col4 + col2 : COLOUR_WHITE;
						res_b_q     <= esc_q ? col8 + col4 : COLOUR_WHITE;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers (no reset needed)
	always_ff @(posedge clk) begin
		if (pixel_acc) begin
			cr_q <= cr_x[C_FRAC +: W];
			ci_q <= ci_x[C_FRAC +: W];
			x_q  <= pixel.pixel_x;
			y_q  <= pixel.pixel_y;
			re_q <= '0;
			im_q <= '0;
			rr_q <= '0;
			ii_q <= '0;
		end
		if (state_q == ST_UPD) begin
			re_q <= re_n;
			im_q <= im_n;
		end
		if (mul_start) begin
			a_q    <= mul_a;
			b_sh_q <= BW'(mul_b);
		end else if (state_q == ST_MUL) begin
			b_sh_q <= b_sh_q << MUL_DIGIT;
		end
		if (state_q == ST_MUL) begin
			pp_s1 <= pp_d;
			if (mcnt_q != '0) begin
				acc_q <= acc_d;
			end
			if (mul_last) begin
				case (op_q)
					OP_RI:   ri_q <= prod;
					OP_RR:   rr_q <= prod;
					OP_II:   ii_q <= prod;
					default: ri_q <= prod;
				endcase
			end
		end
	end

`ifndef SYNTHESIS
	// an escape always takes at least one step
	a_esc_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.escaped |-> result.iterations != '0)
		else $error("escaped pixel reported with zero iterations");

	// a pixel inside the set ran the full limit
	a_inside_full: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.escaped |-> result.iterations == max_q)
		else $error("non-escaped pixel stopped short of the limit");

	// the step count never passes the limit
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> cnt_q <= max_q)
		else $error("step count beyond iteration limit");

	// digit counter stays within one product
	a_mcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> mcnt_q <= MCW'(NCH))
		else $error("multiplier digit counter overrun");

	// a result only appears from the finish state
	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside finish state");
`endif

endmodule

// File: tb/testbench.sv
// Testbench for the escape-time pixel engine: predicted results checked beat by beat.
`timescale 1ns / 1ps

module testbench;
	import mbe_pkg::*;

	localparam int FRAC  = 28;           // Q8.FRAC inside the engine
	localparam int COORD = 12;
	localparam int Q_ONE = 1 << C_FRAC;  // 1.0 in Q4.28 on the pixel channel

	localparam longint Z_TWO  = longint'(2) << FRAC;
	localparam longint Z_FOUR = longint'(4) << FRAC;
	localparam longint Z_MAX  = (longint'(1) << (FRAC + 7)) - 1;

	// Well above the slowest legal run, stalls and all.
	localparam int CYCLE_LIMIT = 30_000_000;

	typedef struct {
		logic [COORD-1:0]       x;
		logic [COORD-1:0]       y;
		logic [ITER_BITS-1:0]   iters;
		logic                   esc;
		logic [COLOUR_BITS-1:0] red;
		logic [COLOUR_BITS-1:0] green;
		logic [COLOUR_BITS-1:0] blue;
	} pixel_result_t;

	logic clk;
	logic arst_n;

	mbe_cfg_if                          cfg_ch ();
	mbe_pixel_if  #(.COORD_BITS(COORD)) pix_ch ();
	mbe_result_if #(.COORD_BITS(COORD)) res_ch ();

	mandelbrot_escape_time_core #(
		.FRAC_BITS (FRAC),
		.COORD_BITS(COORD)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_ch),
		.pixel (pix_ch),
		.result(res_ch)
	);

	pixel_result_t        pending_pixels[$];  // predicted results, oldest first
	logic [ITER_BITS-1:0] iter_limit;         // our copy of the limit register
	int                   mismatches;
	int                   cycle_count;
	bit                   calm;               // set for the closing stretch: no idling

	// 4 ns clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: a hang or a lost result ends the run here.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Fixed-point predictor
	// ---------------------------------------------------------------------

	// Exact signed product, then arithmetic shift by FRAC (rounds to -inf).
	function automatic longint q_mul(input longint a, input longint b);
		logic signed [127:0] wa;
		logic signed [127:0] wb;
		logic signed [127:0] wide;
		wa = a;
		wb = b;
		wide = wa * wb;
		return longint'(wide >>> FRAC);
	endfunction

	// Saturate to the signed FRAC+8 bit range of the z registers.
	function automatic longint q_clamp(input longint v);
		if (v > Z_MAX)
			return Z_MAX;
		if (v < -Z_MAX - 1)
			return -Z_MAX - 1;
		return v;
	endfunction

	// Iterate z = z*z + c from zero; count steps up to the limit.
	function automatic pixel_result_t escape_time(
		input logic signed [C_BITS-1:0] c_re,
		input logic signed [C_BITS-1:0] c_im,
		input logic [COORD-1:0]         px,
		input logic [COORD-1:0]         py,
		input logic [ITER_BITS-1:0]     limit
	);
		longint               cr;
		longint               ci;
		longint               zr;
		longint               zi;
		longint               rr;
		longint               ii;
		longint               ri;
		logic [ITER_BITS-1:0] n;
		bit                   esc;
		pixel_result_t        res;
		// Q4.28 -> Q8.FRAC alignment (a no-op at FRAC = 28)
		cr  = longint'(c_re) <<< (FRAC - C_FRAC);
		ci  = longint'(c_im) <<< (FRAC - C_FRAC);
		zr  = 0;
		zi  = 0;
		n   = '0;
		esc = 1'b0;
		while (!esc && n < limit) begin
			rr = q_mul(zr, zr);
			ii = q_mul(zi, zi);
			ri = q_mul(zr, zi);
			zr = q_clamp(rr - ii + cr);
			zi = q_clamp(2 * ri + ci);
			n++;
			// bound test first, the sum of squares only once both parts are small
			if (zr >= Z_TWO || zr <= -Z_TWO || zi >= Z_TWO || zi <= -Z_TWO)
				esc = 1'b1;
			else if (q_mul(zr, zr) + q_mul(zi, zi) >= Z_FOUR)
				esc = 1'b1;
		end
		res.x     = px;
		res.y     = py;
		res.iters = n;
		res.esc   = esc;
		if (esc) begin
			res.red   = COLOUR_BITS'(n * 16'd8);
			res.green = COLOUR_BITS'(n * 16'd6);
			res.blue  = COLOUR_BITS'(n * 16'd12);
		end else begin
			// never escaped: white
			res.red   = COLOUR_WHITE;
			res.green = COLOUR_WHITE;
			res.blue  = COLOUR_WHITE;
		end
		return res;
	endfunction

	// ---------------------------------------------------------------------
	// Result side: random back-pressure and the scoreboard
	// ---------------------------------------------------------------------

	// Ready drops in random bursts; changes on the falling edge.
	initial begin : result_stall
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 7) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
		end
	end

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Every result beat is matched against the oldest prediction.
	always @(posedge clk) begin
		pixel_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_pixels.size() == 0) begin
				$error("result beat with no pixel outstanding (x %0d, y %0d)",
					res_ch.out_x, res_ch.out_y);
				mismatches++;
			end else begin
				want = pending_pixels.pop_front();
				check_field("out_x",      want.x,     res_ch.out_x);
				check_field("out_y",      want.y,     res_ch.out_y);
				check_field("iterations", want.iters, res_ch.iterations);
				check_field("escaped",    want.esc,   res_ch.escaped);
				check_field("red",        want.red,   res_ch.red);
				check_field("green",      want.green, res_ch.green);
				check_field("blue",       want.blue,  res_ch.blue);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	// One pixel beat, with an optional idle burst ahead of it. Valid is left
	// high after the beat so back-to-back pixels need no toggle.
	task automatic send_pixel(
		input logic signed [C_BITS-1:0] c_re,
		input logic signed [C_BITS-1:0] c_im,
		input logic [COORD-1:0]         px,
		input logic [COORD-1:0]         py
	);
		@(negedge clk);
		if (!calm && $urandom_range(0, 2) == 0) begin
			pix_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		pix_ch.valid   <= 1'b1;
		pix_ch.c_real  <= c_re;
		pix_ch.c_imag  <= c_im;
		pix_ch.pixel_x <= px;
		pix_ch.pixel_y <= py;
		do
			@(posedge clk);
		while (!pix_ch.ready);
		pending_pixels.insert(pending_pixels.size(),
			escape_time(c_re, c_im, px, py, iter_limit));
	endtask

	// Mostly points around the set, where the step counts are interesting;
	// a quarter anywhere in the Q4.28 range.
	task automatic send_random_pixel();
		logic signed [C_BITS-1:0] c_re;
		logic signed [C_BITS-1:0] c_im;
		if ($urandom_range(0, 3) == 0) begin
			c_re = $urandom;
			c_im = $urandom;
		end else begin
			// real in [-2.25, 0.75], imaginary in [-1.5, 1.5]
			c_re = int'($urandom_range(0, 3 * Q_ONE)) - (9 * (Q_ONE / 4));
			c_im = int'($urandom_range(0, 3 * Q_ONE)) - (3 * Q_ONE / 2);
		end
		send_pixel(c_re, c_im, COORD'($urandom_range(0, (1 << COORD) - 1)),
			COORD'($urandom_range(0, (1 << COORD) - 1)));
	endtask

	// Drop valid and wait until every predicted result has come back.
	task automatic drain();
		@(negedge clk);
		pix_ch.valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
	endtask

	// Limit register write; only called with the engine drained.
	task automatic write_limit(input logic [ITER_BITS-1:0] limit);
		@(negedge clk);
		cfg_ch.valid          <= 1'b1;
		cfg_ch.max_iterations <= limit;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		iter_limit = limit;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Landmark points at the reset limit of 256.
	task automatic test_directed();
		send_pixel(0, 0, 0, 0);                             // origin: inside
		send_pixel(-Q_ONE, 0, 4095, 4095);                  // period-2 bulb centre
		send_pixel(-2 * Q_ONE, 0, 1, 2);                    // tip of the needle
		send_pixel(Q_ONE / 4, 0, 4095, 0);                  // cusp: converges slowly
		send_pixel(Q_ONE / 4 + (Q_ONE >> 10), 0, 0, 4095);  // just past the cusp
		send_pixel(32'sh8000_0000, 32'sh8000_0000, 2048, 2047);  // most negative c
		send_pixel(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 2047, 2048);  // most positive c
		send_pixel(0, Q_ONE, 100, 200);                     // +i: inside
		send_pixel(0, -Q_ONE, 200, 100);                    // -i: inside
		send_pixel(2 * Q_ONE - 1, 0, 3, 3);                 // just under 2 on the real axis
		send_pixel(2 * Q_ONE, 0, 4, 4);                     // re hits the bound on step one
		send_pixel(0, 2 * Q_ONE, 5, 5);                     // im hits the bound
		send_pixel(0, -2 * Q_ONE, 6, 6);                    // im hits the negative bound
		send_pixel(3 * Q_ONE / 2, 3 * Q_ONE / 2, 7, 7);     // parts small, squares over 4
		send_pixel(Q_ONE, Q_ONE, 8, 8);                     // escapes on the second step
		send_pixel(-3 * Q_ONE / 4, Q_ONE / 16, 9, 9);       // neck of the cardioid
		send_pixel(-Q_ONE / 2, Q_ONE / 2, 10, 10);          // well inside
		send_pixel(32'sh5555_5555, 32'shAAAA_AAAA, 2730, 1365);  // alternating bits
		drain();
	endtask

	// Limit register at zero, one and its maximum.
	task automatic test_limit_extremes();
		// zero limit: no step at all, every pixel white with count 0
		write_limit(16'd0);
		send_pixel(0, 0, 11, 12);
		send_pixel(32'sh8000_0000, 32'sh8000_0000, 13, 14);
		send_pixel(3 * Q_ONE, -Q_ONE, 15, 16);
		drain();

		write_limit(16'd1);
		send_pixel(0, 0, 17, 18);                 // inside after one step
		send_pixel(3 * Q_ONE, 0, 19, 20);         // out on the only step
		send_pixel(3 * Q_ONE / 2, 3 * Q_ONE / 2, 21, 22);
		send_pixel(-Q_ONE / 2, Q_ONE / 4, 23, 24);
		drain();

		// Maximum limit: only points that leave, some of them very late.
		write_limit(16'hFFFF);
		send_pixel(3 * Q_ONE, 0, 25, 26);
		send_pixel(Q_ONE / 4 + (Q_ONE >> 10), 0, 27, 28);  // about a hundred steps
		send_pixel(Q_ONE / 4 + (Q_ONE >> 20), 0, 29, 30);  // a few thousand
		send_pixel(Q_ONE / 4 + (Q_ONE >> 22), 0, 31, 32);  // several thousand
		repeat (4)
			send_pixel(int'($urandom_range(2 * Q_ONE, 32'h7FFF_FFFF)), $urandom,
				COORD'($urandom_range(0, 4095)), COORD'($urandom_range(0, 4095)));
		drain();
	endtask

	task automatic run_phase(input logic [ITER_BITS-1:0] limit, input int count);
		drain();
		write_limit(limit);
		repeat (count)
			send_random_pixel();
	endtask

	// Random points under a series of limits; small limits keep the run short.
	task automatic test_random();
		run_phase(16'd3, 150);
		run_phase(16'd20, 250);
		run_phase(ITER_BITS'($urandom_range(2, 99)), 120);
		run_phase(16'd64, 250);
		run_phase(16'd200, 120);
		run_phase(ITER_LIMIT_RST, 80);
		run_phase(16'd700, 40);
		// closing stretch at full rate on both sides
		calm = 1'b1;
		run_phase(16'd48, 100);
		drain();
	endtask

	// ---------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------
	initial begin
		mismatches            = 0;
		calm                  = 1'b0;
		iter_limit            = ITER_LIMIT_RST;
		arst_n                = 1'b0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.max_iterations = '0;
		pix_ch.valid          = 1'b0;
		pix_ch.c_real         = '0;
		pix_ch.c_imag         = '0;
		pix_ch.pixel_x        = '0;
		pix_ch.pixel_y        = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_limit_extremes();
		test_random();

		// let any stray beat show up before the verdict
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
